[sv/skm_pkg.sv]
// shared types, register map and constants of the kalman servo mapper
package skm_pkg;

  localparam int GAIN_BITS     = 16;
  localparam int NOISE_BITS    = 24;
  localparam int PULSE_BITS    = 16;
  localparam int KNOB_BITS     = 12;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [NOISE_BITS-1:0] MEAS_NOISE_RST = 24'd419430;
  localparam logic [NOISE_BITS-1:0] PROC_NOISE_RST = 24'd41943;
  localparam logic [PULSE_BITS-1:0] PULSE_LO_RST   = 16'd2250;
  localparam logic [PULSE_BITS-1:0] PULSE_HI_RST   = 16'd5500;
  localparam logic [KNOB_BITS-1:0]  KNOB_FULL_RST  = 12'd4095;

  typedef enum logic [2:0] {
    REG_MEAS_NOISE = 3'd0,
    REG_PROC_NOISE = 3'd1,
    REG_PULSE_LO   = 3'd2,
    REG_PULSE_HI   = 3'd3,
    REG_KNOB_FULL  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [NOISE_BITS-1:0] meas_noise;
    logic [NOISE_BITS-1:0] proc_noise;
    logic [PULSE_BITS-1:0] pulse_lo;
    logic [PULSE_BITS-1:0] pulse_hi;
    logic [KNOB_BITS-1:0]  knob_full;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAIN_INIT,
    OP_DIV_STEP,
    OP_K_LATCH,
    OP_MUL_COV,
    OP_COV_EST,
    OP_EST_WB,
    OP_MUL_MAP,
    OP_MAP_INIT,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   est_up;
  } skm_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_KGET,
    ST_MULCOV,
    ST_COVEST,
    ST_ESTWB,
    ST_MULMAP,
    ST_MAPINIT,
    ST_MAPDIV,
    ST_PUB
  } state_t;

endpackage

[sv/skm_in_if.sv]
// sample channel: valid, ready and the raw knob reading
interface skm_in_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[sv/skm_out_if.sv]
// result channel: valid, ready, filtered reading and servo pulse width
interface skm_out_if #(
  parameter int SAMPLE_BITS = 12
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered;
  logic [15:0]            pulse;

  modport source (output valid, output filtered, output pulse, input ready);
  modport sink (input valid, input filtered, input pulse, output ready);
endinterface

[sv/skm_cfg.sv]
// apb register file holding noise terms and pulse mapping limits
module skm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [skm_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [skm_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [skm_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output skm_pkg::cfg_t                       cfg
);

  skm_pkg::cfg_t     cfg_r;
  skm_pkg::cfg_t     cfg_nxt;
  skm_pkg::cfg_reg_t idx;
  logic              wr_en;

  assign idx    = skm_pkg::cfg_reg_t'(paddr[skm_pkg::CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        skm_pkg::REG_MEAS_NOISE: cfg_nxt.meas_noise = pwdata[skm_pkg::NOISE_BITS-1:0];
        skm_pkg::REG_PROC_NOISE: cfg_nxt.proc_noise = pwdata[skm_pkg::NOISE_BITS-1:0];
        skm_pkg::REG_PULSE_LO:   cfg_nxt.pulse_lo   = pwdata[skm_pkg::PULSE_BITS-1:0];
        skm_pkg::REG_PULSE_HI:   cfg_nxt.pulse_hi   = pwdata[skm_pkg::PULSE_BITS-1:0];
        skm_pkg::REG_KNOB_FULL:  cfg_nxt.knob_full  = pwdata[skm_pkg::KNOB_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      skm_pkg::REG_MEAS_NOISE: prdata = skm_pkg::CFG_DATA_BITS'(cfg_r.meas_noise);
      skm_pkg::REG_PROC_NOISE: prdata = skm_pkg::CFG_DATA_BITS'(cfg_r.proc_noise);
      skm_pkg::REG_PULSE_LO:   prdata = skm_pkg::CFG_DATA_BITS'(cfg_r.pulse_lo);
      skm_pkg::REG_PULSE_HI:   prdata = skm_pkg::CFG_DATA_BITS'(cfg_r.pulse_hi);
      skm_pkg::REG_KNOB_FULL:  prdata = skm_pkg::CFG_DATA_BITS'(cfg_r.knob_full);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.meas_noise <= skm_pkg::MEAS_NOISE_RST;
      cfg_r.proc_noise <= skm_pkg::PROC_NOISE_RST;
      cfg_r.pulse_lo   <= skm_pkg::PULSE_LO_RST;
      cfg_r.pulse_hi   <= skm_pkg::PULSE_HI_RST;
      cfg_r.knob_full  <= skm_pkg::KNOB_FULL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/skm_ctrl.sv]
// sequencer: steps the datapath through gain, update and pulse mapping
module skm_ctrl #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              est_up,
  output skm_pkg::skm_cmd_t cmd
);

  localparam int TW   = SAMPLE_BITS + skm_pkg::PULSE_BITS;
  localparam int CNTW = $clog2(TW);

  skm_pkg::state_t  state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             primed_r, primed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state, step counter and flags
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      skm_pkg::ST_IDLE: begin
        if (in_valid) begin
          primed_nxt = 1'b1;
          cnt_nxt    = CNTW'(skm_pkg::GAIN_BITS - 1);
          if (primed_r) begin
            state_nxt = skm_pkg::ST_GAIN;
          end
        end
      end
      skm_pkg::ST_GAIN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = skm_pkg::ST_KGET;
        end
      end
      skm_pkg::ST_KGET:    state_nxt = skm_pkg::ST_MULCOV;
      skm_pkg::ST_MULCOV:  state_nxt = skm_pkg::ST_COVEST;
      skm_pkg::ST_COVEST:  state_nxt = skm_pkg::ST_ESTWB;
      skm_pkg::ST_ESTWB:   state_nxt = skm_pkg::ST_MULMAP;
      skm_pkg::ST_MULMAP:  state_nxt = skm_pkg::ST_MAPINIT;
      skm_pkg::ST_MAPINIT: begin
        cnt_nxt   = CNTW'(TW - 1);
        state_nxt = skm_pkg::ST_MAPDIV;
      end
      skm_pkg::ST_MAPDIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = skm_pkg::ST_PUB;
        end
      end
      skm_pkg::ST_PUB: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = skm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = skm_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op     = skm_pkg::OP_NONE;
    cmd.est_up = est_up;
    in_ready   = 1'b0;
    unique case (state_r)
      skm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = primed_r ? skm_pkg::OP_GAIN_INIT : skm_pkg::OP_LOAD;
        end
      end
      skm_pkg::ST_GAIN:    cmd.op = skm_pkg::OP_DIV_STEP;
      skm_pkg::ST_KGET:    cmd.op = skm_pkg::OP_K_LATCH;
      skm_pkg::ST_MULCOV:  cmd.op = skm_pkg::OP_MUL_COV;
      skm_pkg::ST_COVEST:  cmd.op = skm_pkg::OP_COV_EST;
      skm_pkg::ST_ESTWB:   cmd.op = skm_pkg::OP_EST_WB;
      skm_pkg::ST_MULMAP:  cmd.op = skm_pkg::OP_MUL_MAP;
      skm_pkg::ST_MAPINIT: cmd.op = skm_pkg::OP_MAP_INIT;
      skm_pkg::ST_MAPDIV:  cmd.op = skm_pkg::OP_DIV_STEP;
      skm_pkg::ST_PUB: begin
        if (slot_free) begin
          cmd.op = skm_pkg::OP_PUBLISH;
        end
      end
      default: cmd.op = skm_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skm_pkg::ST_IDLE;
      cnt_r       <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == skm_pkg::OP_PUBLISH |-> (!out_valid_r || out_ready))
    else $error("result overwrites a beat still waiting");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == skm_pkg::OP_PUBLISH |=> out_valid_r)
    else $error("published result not presented");

  a_first_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !primed_r) |=> (state_r == skm_pkg::ST_IDLE && primed_r))
    else $error("first sample started an update");

  a_gain_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == skm_pkg::ST_GAIN |-> cnt_r < CNTW'(skm_pkg::GAIN_BITS))
    else $error("gain division runs too long");
`endif

endmodule

[sv/skm_dp.sv]
// datapath: filter state, shared multiplier and shared restoring divider
module skm_dp #(
  parameter int SAMPLE_BITS   = 12,
  parameter int EST_FRAC_BITS = 16,
  parameter int COV_FRAC_BITS = 22
) (
  input  logic                   clk,
  input  skm_pkg::skm_cmd_t      cmd,
  input  skm_pkg::cfg_t          cfg,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   est_up,
  output logic [SAMPLE_BITS-1:0] filtered,
  output logic [15:0]            pulse
);

  localparam int GB = skm_pkg::GAIN_BITS;
  localparam int EW = SAMPLE_BITS + EST_FRAC_BITS;
  localparam int CW = COV_FRAC_BITS + 2;
  localparam int TW = SAMPLE_BITS + skm_pkg::PULSE_BITS;
  localparam int MW = (EW > CW) ? EW : CW;
  localparam int AW = GB + 1;
  localparam int PW = AW + MW;
  localparam int DW = ((CW > skm_pkg::NOISE_BITS) ? CW : skm_pkg::NOISE_BITS) + 1;
  localparam int QW = TW;

  logic [SAMPLE_BITS-1:0] s_r;
  logic [EW-1:0]          est_r;
  logic [CW-1:0]          cov_r;
  logic [GB-1:0]          k_r;
  logic [PW-1:0]          prod_r;
  logic [DW-1:0]          rem_r;
  logic [QW-1:0]          quo_r;
  logic [DW-1:0]          dvs_r;
  logic [SAMPLE_BITS-1:0] filt_r;
  logic [15:0]            pulse_r;

  logic [EW-1:0]          s_ext;
  logic [EW-1:0]          diff;
  logic [EW-1:0]          delta;
  logic [DW-1:0]          den;
  logic                   p_ge_den;
  logic [GB-1:0]          k_calc;
  logic [DW-1:0]          cov_sum;
  logic [CW-1:0]          cov_new;
  logic [15:0]            span;
  logic [DW-1:0]          kdiv;
  logic [AW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic [PW-1:0]          prod_nxt;
  logic [DW:0]            sh;
  logic [DW:0]            trial;
  logic [15:0]            pulse_calc;

  assign s_ext    = {s_r, {EST_FRAC_BITS{1'b0}}};
  assign est_up   = s_ext >= est_r;
  assign diff     = est_up ? (s_ext - est_r) : (est_r - s_ext);
  assign delta    = prod_r[GB +: EW];

  assign den      = DW'(cov_r) + DW'(cfg.meas_noise);
  assign p_ge_den = DW'(cov_r) >= den;

  // zero noise and covariance gives no gain, zero noise alone saturates it
  always_comb begin
    if (den == '0) begin
      k_calc = '0;
    end else if (p_ge_den) begin
      k_calc = '1;
    end else begin
      k_calc = quo_r[GB-1:0];
    end
  end

  assign cov_sum = DW'(prod_r[GB +: CW]) + DW'(cfg.proc_noise);
  assign cov_new = (cov_sum[DW-1:CW] != '0) ? {CW{1'b1}} : cov_sum[CW-1:0];

  assign span = (cfg.pulse_hi >= cfg.pulse_lo) ? (cfg.pulse_hi - cfg.pulse_lo) : 16'd0;
  assign kdiv = (cfg.knob_full == '0) ? DW'(1) : DW'(cfg.knob_full);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      skm_pkg::OP_MUL_COV: begin
        mul_a = {1'b1, {GB{1'b0}}} - {1'b0, k_r};
        mul_b = MW'(cov_r);
      end
      skm_pkg::OP_COV_EST: begin
        mul_a = {1'b0, k_r};
        mul_b = MW'(diff);
      end
      skm_pkg::OP_MUL_MAP: begin
        mul_a = AW'(span);
        mul_b = MW'(est_r[EW-1:EST_FRAC_BITS]);
      end
      default: ;
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // one quotient bit a cycle
  assign sh    = {rem_r, quo_r[QW-1]};
  assign trial = sh - {1'b0, dvs_r};

  assign pulse_calc = (quo_r > QW'(cfg.pulse_hi)) ? 16'd0 : (cfg.pulse_hi - quo_r[15:0]);

  always_ff @(posedge clk) begin
    case (cmd.op)
      skm_pkg::OP_LOAD: begin
        s_r   <= sample;
        est_r <= {sample, {EST_FRAC_BITS{1'b0}}};
        cov_r <= '0;
      end
      skm_pkg::OP_GAIN_INIT: begin
        s_r   <= sample;
        rem_r <= p_ge_den ? '0 : DW'(cov_r);
        quo_r <= '0;
        dvs_r <= den;
      end
      skm_pkg::OP_DIV_STEP: begin
        if (!trial[DW]) begin
          rem_r <= trial[DW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= sh[DW-1:0];
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
      end
      skm_pkg::OP_K_LATCH: k_r <= k_calc;
      skm_pkg::OP_MUL_COV: prod_r <= prod_nxt;
      skm_pkg::OP_COV_EST: begin
        cov_r  <= cov_new;
        prod_r <= prod_nxt;
      end
      skm_pkg::OP_EST_WB: begin
        est_r <= cmd.est_up ? (est_r + delta) : (est_r - delta);
      end
      skm_pkg::OP_MUL_MAP: prod_r <= prod_nxt;
      skm_pkg::OP_MAP_INIT: begin
        rem_r <= '0;
        quo_r <= prod_r[QW-1:0];
        dvs_r <= kdiv;
      end
      skm_pkg::OP_PUBLISH: begin
        filt_r  <= est_r[EW-1:EST_FRAC_BITS];
        pulse_r <= pulse_calc;
      end
      default: ;
    endcase
  end

  assign filtered = filt_r;
  assign pulse    = pulse_r;

endmodule

[sv/scalar_kalman_servo_mapper_core.sv]
// top level of the scalar kalman knob filter with servo pulse mapping
// Each knob sample updates a one-dimensional Kalman estimate and gives one beat
// carrying the integer part of the estimate and an inverted servo pulse width;
// the first sample after reset only seeds the estimate and gives no beat. An
// updating sample occupies the block through gain division and pulse division,
// both on one shared restoring divider that yields one quotient bit per cycle,
// plus sequencing and shared multiplier steps. The seeding sample is taken in
// the idle state. A finished beat waits in the output register while the next
// sample is taken and worked on. Registers sit at byte addresses 0, 4, 8, 12
// and 16 and should be written only while the block is idle.
module scalar_kalman_servo_mapper_core #(
  parameter int SAMPLE_BITS   = 12,
  parameter int EST_FRAC_BITS = 16,
  parameter int COV_FRAC_BITS = 22
) (
  input  logic                              clk,
  input  logic                              rst_n,
  skm_in_if.sink                            in_if,
  skm_out_if.source                         out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [skm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [skm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [skm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  skm_pkg::cfg_t     cfg;
  skm_pkg::skm_cmd_t cmd;
  logic              est_up;

  skm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skm_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .est_up    (est_up),
    .cmd       (cmd)
  );

  skm_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .EST_FRAC_BITS (EST_FRAC_BITS),
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .cfg      (cfg),
    .sample   (in_if.sample),
    .est_up   (est_up),
    .filtered (out_if.filtered),
    .pulse    (out_if.pulse)
  );

endmodule
